### rtl/vsrt_pkg.sv
// Shared constants, types and helpers for the vertex scale/rotate/translate block.
package vsrt_pkg;

   localparam int ANGLE_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int COORD_W     = 32;
   localparam int SINE_BITS   = 15;
   localparam int TRIG_W      = SINE_BITS + 1;
   localparam int ROT_SHIFT   = 15;
   localparam int PIPE_STAGES = 9;
   localparam int CSR_IDX_W   = 3;

   localparam real SINE_AMP = 32767.0;
   localparam real HALF_PI  = 1.5707963267948966;

   localparam logic signed [COORD_W-1:0] SCALE_ONE = 32'sd65536;
   localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE_X,
      CSR_SCALE_Y,
      CSR_SCALE_Z,
      CSR_ROTATION_ANGLES,
      CSR_POSITION_X,
      CSR_POSITION_Y,
      CSR_POSITION_Z
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] value;
      logic                      clip;
   } sat_type;

   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type r;
      priority if (v > SAT_HI) begin
         r.value = SAT_HI[COORD_W-1:0];
         r.clip  = 1'b1;
      end else if (v < SAT_LO) begin
         r.value = SAT_LO[COORD_W-1:0];
         r.clip  = 1'b1;
      end else begin
         r.value = v[COORD_W-1:0];
         r.clip  = 1'b0;
      end
      return r;
   endfunction

endpackage

### rtl/vsrt_if.sv
// Request and response channel interfaces for the vertex transform block.
interface vsrt_req_if
   import vsrt_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [COORD_W-1:0] point_z;

   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface vsrt_rsp_if
   import vsrt_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] out_x;
   logic signed [COORD_W-1:0] out_y;
   logic signed [COORD_W-1:0] out_z;
   logic                      saturated;

   modport source (output valid, out_x, out_y, out_z, saturated, input ready);
   modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

### rtl/vertex_scale_rotate_translate.sv
// Top level: pipelined scale, X-Y-Z rotation and translation of 3D points.
//
//  channel | dir | beat contents                       | handshake
//  --------+-----+-------------------------------------+-------------------
//  req     | in  | point_x, point_y, point_z (Q16.16)  | valid/ready
//  rsp     | out | out_x, out_y, out_z, saturated      | valid/ready
//  csr     | in  | csr_index, csr_write_data           | csr_write_enable
//
// One beat per cycle sustained while the rsp side takes every beat.
// Stages: scale multiply, scale clip, then multiply and sum/clip per rotation
// axis, then translate. Each axis has its own sine ROM read twice per cycle.
// The whole pipe freezes while the rsp register holds an untaken beat.
// Reset (synchronous) clears valid bits and loads register defaults.
module vertex_scale_rotate_translate
   import vsrt_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   localparam int CSR_DATA_W = (3 * ANGLE_BITS > COORD_W) ? 3 * ANGLE_BITS : COORD_W
) (
   input  logic                  clock,
   input  logic                  reset,
   vsrt_req_if.sink              req,
   vsrt_rsp_if.source            rsp,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int QSIZE  = 1 << (ANGLE_BITS - 2);
   localparam int PROD_W = COORD_W + TRIG_W;

   typedef logic [SINE_BITS-1:0] sine_tab_type [QSIZE+1];

   function automatic sine_tab_type build_sine_table();
      sine_tab_type t;
      real          ang;
      for (int k = 0; k <= QSIZE; k++) begin
         ang  = HALF_PI * k / QSIZE;
         t[k] = SINE_BITS'($rtoi(SINE_AMP * $sin(ang) + 0.5));
      end
      return t;
   endfunction

   function automatic logic [ANGLE_BITS-2:0] quarter_addr(input logic [ANGLE_BITS-1:0] a);
      logic [ANGLE_BITS-2:0] idx;
      idx = {1'b0, a[ANGLE_BITS-3:0]};
      return a[ANGLE_BITS-2] ? (ANGLE_BITS-1)'(QSIZE) - idx : idx;
   endfunction

   // configuration registers
   logic signed [COORD_W-1:0]    scale_ff [3];
   logic signed [COORD_W-1:0]    pos_ff   [3];
   logic [3*ANGLE_BITS-1:0]      angles_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            scale_ff[i] <= SCALE_ONE;
            pos_ff[i]   <= '0;
         end
         angles_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCALE_X:         scale_ff[0] <= csr_write_data[COORD_W-1:0];
            CSR_SCALE_Y:         scale_ff[1] <= csr_write_data[COORD_W-1:0];
            CSR_SCALE_Z:         scale_ff[2] <= csr_write_data[COORD_W-1:0];
            CSR_ROTATION_ANGLES: angles_ff   <= csr_write_data[3*ANGLE_BITS-1:0];
            CSR_POSITION_X:      pos_ff[0]   <= csr_write_data[COORD_W-1:0];
            CSR_POSITION_Y:      pos_ff[1]   <= csr_write_data[COORD_W-1:0];
            CSR_POSITION_Z:      pos_ff[2]   <= csr_write_data[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic                   adv;
   logic [PIPE_STAGES-1:0] pipe_v_ff;

   assign adv       = !pipe_v_ff[PIPE_STAGES-1] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_v_ff <= '0;
      end else if (adv) begin
         pipe_v_ff <= {pipe_v_ff[PIPE_STAGES-2:0], req.valid};
      end
   end

   // sine/cosine lookup, one ROM per axis, registered read
   logic [SINE_BITS-1:0] sin_mag_ff [3];
   logic [SINE_BITS-1:0] cos_mag_ff [3];
   logic                 sin_neg_ff [3];
   logic                 cos_neg_ff [3];

   for (genvar g = 0; g < 3; g++) begin : g_trig
      localparam sine_tab_type SINE_TAB = build_sine_table();
      logic [ANGLE_BITS-1:0] sin_angle;
      logic [ANGLE_BITS-1:0] cos_angle;

      assign sin_angle = angles_ff[g*ANGLE_BITS +: ANGLE_BITS];
      assign cos_angle = sin_angle + ANGLE_BITS'(QSIZE);

      always_ff @(posedge clock) begin
         sin_mag_ff[g] <= SINE_TAB[quarter_addr(sin_angle)];
         cos_mag_ff[g] <= SINE_TAB[quarter_addr(cos_angle)];
         sin_neg_ff[g] <= sin_angle[ANGLE_BITS-1];
         cos_neg_ff[g] <= cos_angle[ANGLE_BITS-1];
      end
   end

   // scale stage
   logic signed [COORD_W-1:0]   point [3];
   logic signed [2*COORD_W-1:0] sprod_ff [3];
   logic signed [COORD_W-1:0]   coord_ff [4][3];
   logic                        flag_ff  [4];
   sat_type                     s_sat    [3];

   assign point[0] = req.point_x;
   assign point[1] = req.point_y;
   assign point[2] = req.point_z;

   for (genvar i = 0; i < 3; i++) begin : g_scale
      assign s_sat[i] = sat32(sprod_ff[i] >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sprod_ff[i]    <= point[i] * scale_ff[i];
            coord_ff[0][i] <= s_sat[i].value;
         end
         flag_ff[0] <= s_sat[0].clip | s_sat[1].clip | s_sat[2].clip;
      end
   end

   // rotation stages: X, then Y, then Z
   for (genvar r = 0; r < 3; r++) begin : g_rot
      localparam int U = (r + 1) % 3;
      localparam int W = (r + 2) % 3;

      logic signed [TRIG_W-1:0]  sin_v;
      logic signed [TRIG_W-1:0]  cos_v;
      logic signed [COORD_W-1:0] keep_ff;
      logic                      mflag_ff;
      logic signed [PROD_W-1:0]  uc_ff, ws_ff, us_ff, wc_ff;
      logic signed [PROD_W:0]    u_sum;
      logic signed [PROD_W:0]    w_sum;
      sat_type                   u_sat;
      sat_type                   w_sat;

      assign sin_v = sin_neg_ff[r] ? -$signed({1'b0, sin_mag_ff[r]})
                                   :  $signed({1'b0, sin_mag_ff[r]});
      assign cos_v = cos_neg_ff[r] ? -$signed({1'b0, cos_mag_ff[r]})
                                   :  $signed({1'b0, cos_mag_ff[r]});

      assign u_sum = uc_ff - ws_ff;
      assign w_sum = us_ff + wc_ff;
      assign u_sat = sat32(64'(u_sum >>> ROT_SHIFT));
      assign w_sat = sat32(64'(w_sum >>> ROT_SHIFT));

      always_ff @(posedge clock) begin
         if (adv) begin
            keep_ff  <= coord_ff[r][r];
            mflag_ff <= flag_ff[r];
            uc_ff    <= coord_ff[r][U] * cos_v;
            ws_ff    <= coord_ff[r][W] * sin_v;
            us_ff    <= coord_ff[r][U] * sin_v;
            wc_ff    <= coord_ff[r][W] * cos_v;
            coord_ff[r+1][r] <= keep_ff;
            coord_ff[r+1][U] <= u_sat.value;
            coord_ff[r+1][W] <= w_sat.value;
            flag_ff[r+1]     <= mflag_ff | u_sat.clip | w_sat.clip;
         end
      end
   end

   // translate and output register
   sat_type t_sat [3];

   for (genvar i = 0; i < 3; i++) begin : g_xlate
      logic signed [COORD_W:0] t_sum;
      assign t_sum    = coord_ff[3][i] + pos_ff[i];
      assign t_sat[i] = sat32(64'(t_sum));
   end

   logic signed [COORD_W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic                      saturated_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         out_x_ff     <= t_sat[0].value;
         out_y_ff     <= t_sat[1].value;
         out_z_ff     <= t_sat[2].value;
         saturated_ff <= flag_ff[3] | t_sat[0].clip | t_sat[1].clip | t_sat[2].clip;
      end
   end

   assign rsp.valid     = pipe_v_ff[PIPE_STAGES-1];
   assign rsp.out_x     = out_x_ff;
   assign rsp.out_y     = out_y_ff;
   assign rsp.out_z     = out_z_ff;
   assign rsp.saturated = saturated_ff;

endmodule

### rtl/vsrt_checker.sv
// Port-level assertions for the vertex transform block, bound to the top level.
module vsrt_checker
   import vsrt_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [COORD_W-1:0] out_x,
   input logic signed [COORD_W-1:0] out_y,
   input logic signed [COORD_W-1:0] out_z,
   input logic                      saturated
);

   localparam int CNT_W = $clog2(PIPE_STAGES + 2);

   logic [CNT_W-1:0] inflight_ff;
   logic [CNT_W-1:0] inflight_in;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_valid && req_ready) begin
         inflight_in = inflight_in + CNT_W'(1);
      end
      if (rsp_valid && rsp_ready) begin
         inflight_in = inflight_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({out_x, out_y, out_z, saturated}))
      else $error("stalled rsp beat changed");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != '0)
      else $error("rsp beat without a pending req beat");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNT_W'(PIPE_STAGES))
      else $error("more beats in flight than pipeline stages");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req not ready while output register free");

endmodule

bind vertex_scale_rotate_translate vsrt_checker u_vsrt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .out_x     (rsp.out_x),
   .out_y     (rsp.out_y),
   .out_z     (rsp.out_z),
   .saturated (rsp.saturated)
);

### verif/tb_top.sv
// Self-checking testbench for the vertex scale/rotate/translate block.
module tb_top;
   import vsrt_pkg::*;

   localparam int CSR_DATA_W = (3 * ANGLE_BITS_DEF > COORD_W) ? 3 * ANGLE_BITS_DEF : COORD_W;
   localparam int AB = ANGLE_BITS_DEF;
   localparam int QUARTER = 1 << (AB - 2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
   localparam logic signed [COORD_W-1:0] C_ONE = 32'sh0001_0000;
   localparam int RANDOM_PHASES = 10;
   localparam int ITEMS_PER_PHASE = 172;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vertex_type;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      saturated;
   } placed_type;

   typedef enum {READY_ALWAYS, READY_SPARSE, READY_PERIODIC, READY_COIN} ready_style_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   vsrt_req_if req ();
   vsrt_rsp_if rsp ();

   vertex_scale_rotate_translate i_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   longint sine_quarter [0:QUARTER];
   logic signed [COORD_W-1:0] scale_cfg [3];
   logic [3*AB-1:0]           angle_cfg;
   logic signed [COORD_W-1:0] offset_cfg [3];

   vertex_type vertex_backlog [$];
   placed_type awaited_results [$];
   int beats_queued = 0;
   int beats_sent = 0;
   int mismatches = 0;

   function automatic longint clamp32(input longint v, inout bit clip);
      if (v > longint'(C_MAX)) begin
         clip = 1'b1;
         return longint'(C_MAX);
      end
      if (v < longint'(C_MIN)) begin
         clip = 1'b1;
         return longint'(C_MIN);
      end
      return v;
   endfunction

   function automatic longint sine_code(input logic [AB-1:0] a);
      logic [AB-3:0] idx;
      longint mag;
      idx = a[AB-3:0];
      mag = a[AB-2] ? sine_quarter[QUARTER - idx] : sine_quarter[idx];
      return a[AB-1] ? -mag : mag;
   endfunction

   // u' = u*c - w*s, w' = u*s + w*c
   function automatic void spin(inout longint u, inout longint w, input logic [AB-1:0] a,
                                inout bit clip);
      logic [AB-1:0] a_cos;
      longint s, c, nu;
      a_cos = a + AB'(QUARTER);
      s = sine_code(a);
      c = sine_code(a_cos);
      nu = clamp32((u * c - w * s) >>> ROT_SHIFT, clip);
      w = clamp32((u * s + w * c) >>> ROT_SHIFT, clip);
      u = nu;
   endfunction

   function automatic placed_type transform_vertex(input vertex_type p);
      placed_type r;
      bit clip;
      longint x, y, z;
      clip = 1'b0;
      x = clamp32((longint'(p.x) * longint'(scale_cfg[0])) >>> FRAC_BITS_DEF, clip);
      y = clamp32((longint'(p.y) * longint'(scale_cfg[1])) >>> FRAC_BITS_DEF, clip);
      z = clamp32((longint'(p.z) * longint'(scale_cfg[2])) >>> FRAC_BITS_DEF, clip);
      spin(y, z, angle_cfg[AB-1:0], clip);
      spin(z, x, angle_cfg[2*AB-1:AB], clip);
      spin(x, y, angle_cfg[3*AB-1:2*AB], clip);
      x = clamp32(x + longint'(offset_cfg[0]), clip);
      y = clamp32(y + longint'(offset_cfg[1]), clip);
      z = clamp32(z + longint'(offset_cfg[2]), clip);
      r.x = x[COORD_W-1:0];
      r.y = y[COORD_W-1:0];
      r.z = z[COORD_W-1:0];
      r.saturated = clip;
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_coord();
      logic signed [COORD_W-1:0] v;
      v = $urandom;
      case ($urandom_range(0, 3))
         0: ;
         1: v = v >>> $urandom_range(4, 30);
         2: v = v >>> 14;
         default: begin
            case ($urandom_range(0, 4))
               0: v = C_MAX;
               1: v = C_MIN;
               2: v = '0;
               3: v = 1;
               default: v = -1;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_scale();
      logic signed [COORD_W-1:0] v;
      v = $urandom;
      case ($urandom_range(0, 4))
         0: ;
         1, 2: v = v >>> $urandom_range(13, 20);
         3: v = ($urandom_range(0, 1) ? C_ONE : -C_ONE) + (v >>> 20);
         default: begin
            case ($urandom_range(0, 3))
               0: v = C_MAX;
               1: v = C_MIN;
               2: v = '0;
               default: v = -C_ONE;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic logic [3*AB-1:0] pick_angles();
      logic [63:0] raw;
      logic [3*AB-1:0] v;
      raw = {$urandom, $urandom};
      v = raw[3*AB-1:0];
      if ($urandom_range(0, 2) == 0) begin
         for (int k = 0; k < 3; k++) begin
            v[k*AB +: AB] = AB'((QUARTER * $urandom_range(0, 3) + $urandom_range(0, 2) - 1)
                                % (1 << AB));
         end
      end
      return v;
   endfunction

   task automatic program_register(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_SCALE_X:         scale_cfg[0] = data[COORD_W-1:0];
         CSR_SCALE_Y:         scale_cfg[1] = data[COORD_W-1:0];
         CSR_SCALE_Z:         scale_cfg[2] = data[COORD_W-1:0];
         CSR_ROTATION_ANGLES: angle_cfg = data[3*AB-1:0];
         CSR_POSITION_X:      offset_cfg[0] = data[COORD_W-1:0];
         CSR_POSITION_Y:      offset_cfg[1] = data[COORD_W-1:0];
         CSR_POSITION_Z:      offset_cfg[2] = data[COORD_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Upper data bits above a 32-bit register get junk; the block must drop them.
   task automatic apply_setting(input logic signed [COORD_W-1:0] sx, sy, sz,
                                input logic [3*AB-1:0] angles,
                                input logic signed [COORD_W-1:0] px, py, pz);
      logic [CSR_DATA_W-COORD_W-1:0] junk;
      junk = (CSR_DATA_W-COORD_W)'($urandom);
      program_register(CSR_SCALE_X, {junk, sx});
      program_register(CSR_SCALE_Y, {~junk, sy});
      program_register(CSR_SCALE_Z, {junk, sz});
      program_register(CSR_ROTATION_ANGLES, angles);
      program_register(CSR_POSITION_X, {~junk, px});
      program_register(CSR_POSITION_Y, {junk, py});
      program_register(CSR_POSITION_Z, {~junk, pz});
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_vertex(input logic signed [COORD_W-1:0] x, y, z);
      vertex_type v;
      v.x = x;
      v.y = y;
      v.z = z;
      vertex_backlog.push_back(v);
      beats_queued++;
   endtask

   task automatic queue_directed_vertices();
      queue_vertex('0, '0, '0);
      queue_vertex(C_MAX, C_MAX, C_MAX);
      queue_vertex(C_MIN, C_MIN, C_MIN);
      queue_vertex(C_MAX, C_MIN, '0);
      queue_vertex(1, -1, C_ONE);
      queue_vertex(-C_ONE, C_MIN, C_MAX);
      queue_vertex(32'sh0001_8000, -32'sh0002_4000, 32'sh0000_7FFF);
      queue_vertex(C_MIN, '0, -1);
   endtask

   task automatic wait_until_settled();
      while (beats_sent != beats_queued || awaited_results.size() != 0) @(posedge clock);
   endtask

   // Sender: bursts of random length, random gaps between them.
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      vertex_type sent;
      vertex_type nxt;
      if (reset) begin
         req.valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req.valid && req.ready) begin
            sent.x = req.point_x;
            sent.y = req.point_y;
            sent.z = req.point_z;
            awaited_results.push_back(transform_vertex(sent));
            beats_sent++;
         end
         if (!req.valid || req.ready) begin
            if (gap_left > 0 || vertex_backlog.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req.valid <= 1'b0;
            end else begin
               nxt = vertex_backlog.pop_front();
               req.valid <= 1'b1;
               req.point_x <= nxt.x;
               req.point_y <= nxt.y;
               req.point_z <= nxt.z;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                           : $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   task automatic report_field(input string name, input logic [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d (0x%h), got %0d (0x%h)", $time, name,
                  $signed(want), want, $signed(got), got);
         mismatches++;
      end
   endtask

   // Receiver: stall style switches at random among four patterns.
   ready_style_type ready_style;
   int style_left;
   int cycle_count;

   always @(posedge clock) begin
      placed_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
         ready_style = READY_ALWAYS;
         style_left = 0;
         cycle_count = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected beat, expected none, got x=%0d y=%0d z=%0d sat=%0b",
                        $time, rsp.out_x, rsp.out_y, rsp.out_z, rsp.saturated);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               report_field("out_x", want.x, rsp.out_x);
               report_field("out_y", want.y, rsp.out_y);
               report_field("out_z", want.z, rsp.out_z);
               report_field("saturated", COORD_W'(want.saturated), COORD_W'(rsp.saturated));
            end
         end
         cycle_count++;
         if (style_left == 0) begin
            ready_style = ready_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(20, 300);
         end else begin
            style_left--;
         end
         case (ready_style)
            READY_ALWAYS:   rsp.ready <= 1'b1;
            READY_SPARSE:   rsp.ready <= ($urandom_range(0, 3) == 0);
            READY_PERIODIC: rsp.ready <= (cycle_count % 7 >= 3);
            default:        rsp.ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   initial begin
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      reset = 1'b1;
      for (int k = 0; k <= QUARTER; k++) begin
         sine_quarter[k] = $rtoi(32767.0 * $sin(k * HALF_PI / QUARTER) + 0.5);
      end
      for (int k = 0; k < 3; k++) begin
         scale_cfg[k] = SCALE_ONE;
         offset_cfg[k] = '0;
      end
      angle_cfg = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults; a write to an unmapped index must change nothing
      program_register(CSR_UNMAPPED, '1);
      csr_write_enable <= 1'b0;
      queue_directed_vertices();
      wait_until_settled();

      // full-range scale and offset, quadrant-edge angles
      apply_setting(C_MAX, C_MIN, '0, {12'd3072, 12'd2048, 12'd1024}, C_MAX, C_MIN, '0);
      queue_directed_vertices();
      wait_until_settled();

      apply_setting(-C_ONE, -C_ONE, -C_ONE, '1, C_MIN, C_MAX, -C_ONE);
      queue_directed_vertices();
      wait_until_settled();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         apply_setting(pick_scale(), pick_scale(), pick_scale(), pick_angles(),
                       pick_coord(), pick_coord(), pick_coord());
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            queue_vertex(pick_coord(), pick_coord(), pick_coord());
         end
         wait_until_settled();
      end

      repeat (PIPE_STAGES + 4) @(posedge clock);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("PASS vertex_scale_rotate_translate");
      end else begin
         $display("FAIL vertex_scale_rotate_translate");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL vertex_scale_rotate_translate");
      $finish;
   end

endmodule

### vertex_scale_rotate_translate.f
rtl/vsrt_pkg.sv
rtl/vsrt_if.sv
rtl/vertex_scale_rotate_translate.sv
rtl/vsrt_checker.sv
verif/tb_top.sv
